// ===== rtl/core/region_list_boot_allocator_unit_defines.svh =====
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef REGION_LIST_BOOT_ALLOCATOR_UNIT_DEFINES_SVH
`define REGION_LIST_BOOT_ALLOCATOR_UNIT_DEFINES_SVH

`define RLBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define RLBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RLBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rlba_pkg.sv =====
`default_nettype none
package rlba_pkg;

  localparam int unsigned DATA_W = 64;

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_FINISH  = 3'd2,
    KIND_ALLOC   = 3'd3,
    KIND_RESERVE = 3'd4,
    KIND_CHECK   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_NOROOM = 2'd3
  } status_e;

  localparam logic CFG_KERNEL_BASE = 1'b0;
  localparam logic CFG_KERNEL_END  = 1'b1;

  // compare results of one table entry against a window
  typedef struct packed {
    logic [DATA_W-1:0] ent_end;
    logic              base_le_lo;
    logic              base_lt_hi;
    logic              end_gt_lo;
    logic              end_ge_hi;
  } span_t;

  function automatic logic [DATA_W-1:0] align_up(input logic [DATA_W-1:0] x,
                                                 input logic [5:0] lg);
    logic [DATA_W-1:0] m;
    m = (DATA_W'(1) << lg) - DATA_W'(1);
    return (x + m) & ~m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/region_list_boot_allocator_unit.sv =====
// Boot memory region allocator. Holds a table of free regions and a sorted, merged table of
// reserved regions, each in a memory of REGION_SLOTS entries with one write and one read
// port, and runs one command at a time under a sequencer that reads one entry at a time and
// shares one compare/add unit. A reservation merges the new region into the reserved table
// entry by entry; finish also reserves the kernel range, then insertion-sorts the free table;
// alloc walks free regions and, per candidate, reserved entries, then carves and reserves;
// check scans reserved entries. The input side is ready only between commands; a finished
// result sits in an output register, so the next command may start while it waits. Tables
// need no clearing after reset.
`default_nettype none
`include "region_list_boot_allocator_unit_defines.svh"
module region_list_boot_allocator_unit #(
  parameter int unsigned REGION_SLOTS = 32,
  parameter int unsigned ADDRESS_BITS = 52
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic                    cfg_addr_i,
  input  wire logic [ADDRESS_BITS-1:0] cfg_data_i,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // base, size, alignment_log2, available
  input  wire logic [((2*ADDRESS_BITS+8+7)/8)*8-1:0] s_axis_tdata_i,
  // kind
  input  wire logic [2:0]              s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // address, reserved_hit, status, total_free, total_reserved
  output logic [((ADDRESS_BITS+131+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned DW    = rlba_pkg::DATA_W;
  localparam int unsigned AB    = ADDRESS_BITS;
  localparam int unsigned SZ_W  = AB + 1;
  localparam int unsigned ENT_W = AB + SZ_W;
  localparam int unsigned IDX_W = $clog2(REGION_SLOTS);
  localparam int unsigned CNT_W = $clog2(REGION_SLOTS + 1);
  localparam int unsigned OUT_W = ((ADDRESS_BITS + 131 + 7) / 8) * 8;
  localparam logic [DW-1:0]    SPAN    = DW'(1) << AB;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(REGION_SLOTS);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RSV_CHK, S_MRG_RD, S_MRG_EV, S_MRG_FLUSH,
    S_SORT_KEY_RD, S_SORT_KEY_EV, S_SORT_CMP_RD, S_SORT_CMP_EV,
    S_ALC_FREE_RD, S_ALC_FREE_EV, S_ALC_WHILE, S_ALC_HELD_RD, S_ALC_HELD_EV, S_ALC_FOUND,
    S_CRV_RD, S_CRV_EV, S_CRV_APPEND, S_CRV_MOVE_RD, S_CRV_MOVE_EV,
    S_CHK_RD, S_CHK_EV, S_DONE
  } state_e;

  state_e              state_q, state_d;
  rlba_pkg::kind_e     op_q, op_d;
  logic                avail_q, avail_d;
  logic [5:0]          lg_q, lg_d;
  logic [DW-1:0]       cand_q, cand_d, re_q, re_d, right_q, right_d;
  logic [DW-1:0]       size_q, size_d, rv_base_q, rv_base_d, rv_size_q, rv_size_d;
  logic [CNT_W-1:0]    i_q, i_d, j_q, j_d;
  logic [ENT_W-1:0]    key_q, key_d;
  logic                cur_val_q, cur_val_d, new_pend_q, new_pend_d;
  logic [DW-1:0]       cur_base_q, cur_base_d, cur_end_q, cur_end_d;
  logic [AB-1:0]       addr_q, addr_d;
  logic                hit_q, hit_d;
  rlba_pkg::status_e   status_q, status_d;
  logic [DW-1:0]       free_tot_q, free_tot_d, held_tot_q, held_tot_d;
  logic [CNT_W-1:0]    free_cnt_q, free_cnt_d, held_cnt_q, held_cnt_d;
  logic [AB-1:0]       kbase_q, kbase_d, kend_q, kend_d;
  logic                out_val_q, out_val_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  logic                free_we, free_re, held_we, held_re;
  logic [IDX_W-1:0]    free_wa, free_ra, held_wa, held_ra;
  logic [ENT_W-1:0]    free_wd, held_wd, free_rd, held_rd;

  logic [DW-1:0]       fq_base, fq_size, hq_base, hq_size, kq_base;
  logic [DW-1:0]       cand_end, cur_len, left_len, right_len, e_base, e_size;
  logic [DW-1:0]       sp_base, sp_size, sp_lo, sp_hi;
  logic [CNT_W-1:0]    i_nx, j_nx, j_pv;
  logic                mem_av, pick_new, in_acc;
  rlba_pkg::span_t     sp;

  rlba_table #(.DEPTH(REGION_SLOTS), .WIDTH(ENT_W)) u_free_tbl (
    .clk_i     (clk_i),
    .wr_en_i   (free_we),
    .wr_addr_i (free_wa),
    .wr_data_i (free_wd),
    .rd_en_i   (free_re),
    .rd_addr_i (free_ra),
    .rd_data_o (free_rd)
  );

  rlba_table #(.DEPTH(REGION_SLOTS), .WIDTH(ENT_W)) u_held_tbl (
    .clk_i     (clk_i),
    .wr_en_i   (held_we),
    .wr_addr_i (held_wa),
    .wr_data_i (held_wd),
    .rd_en_i   (held_re),
    .rd_addr_i (held_ra),
    .rd_data_o (held_rd)
  );

  rlba_span_unit u_span (
    .ent_base_i (sp_base),
    .ent_size_i (sp_size),
    .win_lo_i   (sp_lo),
    .win_hi_i   (sp_hi),
    .span_o     (sp)
  );

  assign fq_base   = DW'(free_rd[AB-1:0]);
  assign fq_size   = DW'(free_rd[ENT_W-1:AB]);
  assign hq_base   = DW'(held_rd[AB-1:0]);
  assign hq_size   = DW'(held_rd[ENT_W-1:AB]);
  assign kq_base   = DW'(key_q[AB-1:0]);
  assign cand_end  = cand_q + size_q;
  assign cur_len   = cur_end_q - cur_base_q;
  assign left_len  = cand_q - fq_base;
  assign right_len = sp.ent_end - cand_end;
  assign i_nx      = i_q + ONE_C;
  assign j_nx      = j_q + ONE_C;
  assign j_pv      = j_q - ONE_C;
  assign mem_av    = i_q < held_cnt_q;
  assign pick_new  = new_pend_q && (!mem_av || (rv_base_q < hq_base));
  assign e_base    = pick_new ? rv_base_q : hq_base;
  assign e_size    = pick_new ? rv_size_q : hq_size;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_val_q;
  assign m_axis_tdata_o  = out_data_q;

  // operand selection for the shared compare unit
  always_comb begin
    sp_base = fq_base;
    sp_size = fq_size;
    sp_lo   = cand_q;
    sp_hi   = cand_end;
    case (state_q)
      S_ALC_HELD_EV, S_CHK_EV: begin
        sp_base = hq_base;
        sp_size = hq_size;
      end
      S_MRG_EV: begin
        sp_base = e_base;
        sp_size = e_size;
        sp_lo   = cur_end_q;
        sp_hi   = cur_end_q;
      end
      S_SORT_CMP_EV: begin
        sp_lo = kq_base;
        sp_hi = kq_base;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    avail_d    = avail_q;
    lg_d       = lg_q;
    cand_d     = cand_q;
    re_d       = re_q;
    right_d    = right_q;
    size_d     = size_q;
    rv_base_d  = rv_base_q;
    rv_size_d  = rv_size_q;
    i_d        = i_q;
    j_d        = j_q;
    key_d      = key_q;
    cur_val_d  = cur_val_q;
    new_pend_d = new_pend_q;
    cur_base_d = cur_base_q;
    cur_end_d  = cur_end_q;
    addr_d     = addr_q;
    hit_d      = hit_q;
    status_d   = status_q;
    free_tot_d = free_tot_q;
    held_tot_d = held_tot_q;
    free_cnt_d = free_cnt_q;
    held_cnt_d = held_cnt_q;
    kbase_d    = kbase_q;
    kend_d     = kend_q;
    out_val_d  = out_val_q;
    out_data_d = out_data_q;
    free_we    = 1'b0;
    free_wa    = j_q[IDX_W-1:0];
    free_wd    = key_q;
    free_re    = 1'b0;
    free_ra    = i_q[IDX_W-1:0];
    held_we    = 1'b0;
    held_wa    = j_q[IDX_W-1:0];
    held_wd    = {cur_len[SZ_W-1:0], cur_base_q[AB-1:0]};
    held_re    = 1'b0;
    held_ra    = i_q[IDX_W-1:0];

    if (cfg_valid_i) begin
      if (cfg_addr_i == rlba_pkg::CFG_KERNEL_BASE) begin
        kbase_d = cfg_data_i;
      end else begin
        kend_d = cfg_data_i;
      end
    end

    if (out_val_q && m_axis_tready_i) begin
      out_val_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = rlba_pkg::kind_e'(s_axis_tuser_i);
          rv_base_d = DW'(s_axis_tdata_i[AB-1:0]);
          rv_size_d = DW'(s_axis_tdata_i[ENT_W-1:AB]);
          size_d    = DW'(s_axis_tdata_i[ENT_W-1:AB]);
          cand_d    = DW'(s_axis_tdata_i[AB-1:0]);
          lg_d      = s_axis_tdata_i[ENT_W+5:ENT_W];
          avail_d   = s_axis_tdata_i[ENT_W+6];
          addr_d    = '0;
          hit_d     = 1'b0;
          status_d  = rlba_pkg::STAT_OK;
          state_d   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_DONE;
        case (op_q)
          rlba_pkg::KIND_CLEAR: begin
            free_cnt_d = '0;
            held_cnt_d = '0;
            free_tot_d = '0;
            held_tot_d = '0;
          end
          rlba_pkg::KIND_ADD: begin
            if (!avail_q) begin
              state_d = S_RSV_CHK;
            end else if (rv_size_q == '0) begin
              state_d = S_DONE;
            end else if (rv_size_q > SPAN || rv_base_q > SPAN - rv_size_q) begin
              status_d = rlba_pkg::STAT_RANGE;
            end else if (free_cnt_q >= SLOTS_C) begin
              status_d = rlba_pkg::STAT_FULL;
            end else begin
              free_we    = 1'b1;
              free_wa    = free_cnt_q[IDX_W-1:0];
              free_wd    = {rv_size_q[SZ_W-1:0], rv_base_q[AB-1:0]};
              free_cnt_d = free_cnt_q + ONE_C;
              free_tot_d = free_tot_q + rv_size_q;
            end
          end
          rlba_pkg::KIND_FINISH: begin
            if (kend_q < kbase_q) begin
              status_d = rlba_pkg::STAT_RANGE;
            end else begin
              rv_base_d = DW'(kbase_q);
              rv_size_d = DW'(kend_q - kbase_q);
              state_d   = S_RSV_CHK;
            end
          end
          rlba_pkg::KIND_ALLOC: begin
            if (size_q == '0 || size_q > SPAN) begin
              status_d = rlba_pkg::STAT_NOROOM;
            end else begin
              i_d     = '0;
              state_d = S_ALC_FREE_RD;
            end
          end
          rlba_pkg::KIND_RESERVE: begin
            state_d = S_RSV_CHK;
          end
          rlba_pkg::KIND_CHECK: begin
            if (size_q != '0) begin
              j_d     = '0;
              state_d = S_CHK_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_RSV_CHK: begin
        state_d = S_DONE;
        if (rv_size_q == '0) begin
          if (op_q == rlba_pkg::KIND_FINISH) begin
            i_d     = ONE_C;
            state_d = S_SORT_KEY_RD;
          end
        end else if (rv_size_q > SPAN || rv_base_q > SPAN - rv_size_q) begin
          if (op_q != rlba_pkg::KIND_ALLOC) begin
            status_d = rlba_pkg::STAT_RANGE;
          end
        end else if (held_cnt_q >= SLOTS_C) begin
          if (op_q != rlba_pkg::KIND_ALLOC) begin
            status_d = rlba_pkg::STAT_FULL;
          end
        end else begin
          held_tot_d = held_tot_q + rv_size_q;
          i_d        = '0;
          j_d        = '0;
          cur_val_d  = 1'b0;
          new_pend_d = 1'b1;
          state_d    = (held_cnt_q != '0) ? S_MRG_RD : S_MRG_EV;
        end
      end

      S_MRG_RD: begin
        held_re = 1'b1;
        state_d = S_MRG_EV;
      end

      S_MRG_EV: begin
        if (!cur_val_q) begin
          cur_val_d  = 1'b1;
          cur_base_d = e_base;
          cur_end_d  = sp.ent_end;
        end else if (sp.base_le_lo) begin
          if (sp.end_gt_lo) begin
            cur_end_d = sp.ent_end;
          end
        end else begin
          held_we    = 1'b1;
          j_d        = j_nx;
          cur_base_d = e_base;
          cur_end_d  = sp.ent_end;
        end
        if (pick_new) begin
          new_pend_d = 1'b0;
          state_d    = mem_av ? S_MRG_EV : S_MRG_FLUSH;
        end else begin
          i_d = i_nx;
          if (i_nx < held_cnt_q) begin
            state_d = S_MRG_RD;
          end else if (new_pend_q) begin
            state_d = S_MRG_EV;
          end else begin
            state_d = S_MRG_FLUSH;
          end
        end
      end

      S_MRG_FLUSH: begin
        held_we    = 1'b1;
        held_cnt_d = j_nx;
        if (op_q == rlba_pkg::KIND_FINISH) begin
          i_d     = ONE_C;
          state_d = S_SORT_KEY_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SORT_KEY_RD: begin
        if (i_q < free_cnt_q) begin
          free_re = 1'b1;
          state_d = S_SORT_KEY_EV;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SORT_KEY_EV: begin
        key_d   = free_rd;
        j_d     = i_q;
        state_d = S_SORT_CMP_RD;
      end

      S_SORT_CMP_RD: begin
        if (j_q != '0) begin
          free_re = 1'b1;
          free_ra = j_pv[IDX_W-1:0];
          state_d = S_SORT_CMP_EV;
        end else begin
          free_we = 1'b1;
          i_d     = i_nx;
          state_d = S_SORT_KEY_RD;
        end
      end

      S_SORT_CMP_EV: begin
        free_we = 1'b1;
        if (!sp.base_le_lo) begin
          free_wd = free_rd;
          j_d     = j_pv;
          state_d = S_SORT_CMP_RD;
        end else begin
          i_d     = i_nx;
          state_d = S_SORT_KEY_RD;
        end
      end

      S_ALC_FREE_RD: begin
        if (i_q < free_cnt_q) begin
          free_re = 1'b1;
          state_d = S_ALC_FREE_EV;
        end else begin
          status_d = rlba_pkg::STAT_NOROOM;
          state_d  = S_DONE;
        end
      end

      S_ALC_FREE_EV: begin
        re_d    = sp.ent_end;
        cand_d  = rlba_pkg::align_up(fq_base, lg_q);
        j_d     = '0;
        state_d = S_ALC_WHILE;
      end

      S_ALC_WHILE: begin
        if (cand_end <= re_q) begin
          state_d = S_ALC_HELD_RD;
        end else begin
          i_d     = i_nx;
          state_d = S_ALC_FREE_RD;
        end
      end

      S_ALC_HELD_RD: begin
        if (j_q < held_cnt_q) begin
          held_re = 1'b1;
          held_ra = j_q[IDX_W-1:0];
          state_d = S_ALC_HELD_EV;
        end else begin
          state_d = S_ALC_FOUND;
        end
      end

      S_ALC_HELD_EV: begin
        if (!sp.base_lt_hi) begin
          state_d = S_ALC_FOUND;
        end else if (sp.end_gt_lo) begin
          cand_d  = rlba_pkg::align_up(sp.ent_end, lg_q);
          j_d     = j_nx;
          state_d = S_ALC_WHILE;
        end else begin
          j_d     = j_nx;
          state_d = S_ALC_HELD_RD;
        end
      end

      S_ALC_FOUND: begin
        if (held_cnt_q >= SLOTS_C) begin
          status_d = rlba_pkg::STAT_FULL;
          state_d  = S_DONE;
        end else begin
          addr_d  = cand_q[AB-1:0];
          j_d     = '0;
          state_d = S_CRV_RD;
        end
      end

      S_CRV_RD: begin
        if (j_q < free_cnt_q) begin
          free_re = 1'b1;
          free_ra = j_q[IDX_W-1:0];
          state_d = S_CRV_EV;
        end else begin
          rv_base_d = cand_q;
          rv_size_d = size_q;
          state_d   = S_RSV_CHK;
        end
      end

      S_CRV_EV: begin
        if (!(sp.base_le_lo && sp.end_ge_hi)) begin
          j_d     = j_nx;
          state_d = S_CRV_RD;
        end else begin
          free_tot_d = free_tot_q - size_q;
          rv_base_d  = cand_q;
          rv_size_d  = size_q;
          right_d    = right_len;
          state_d    = S_RSV_CHK;
          if (left_len != '0) begin
            free_we = 1'b1;
            free_wd = {left_len[SZ_W-1:0], fq_base[AB-1:0]};
            if (right_len != '0 && free_cnt_q < SLOTS_C) begin
              state_d = S_CRV_APPEND;
            end
          end else if (right_len != '0) begin
            free_we = 1'b1;
            free_wd = {right_len[SZ_W-1:0], cand_end[AB-1:0]};
          end else begin
            free_cnt_d = free_cnt_q - ONE_C;
            state_d    = S_CRV_MOVE_RD;
          end
        end
      end

      S_CRV_APPEND: begin
        free_we    = 1'b1;
        free_wa    = free_cnt_q[IDX_W-1:0];
        free_wd    = {right_q[SZ_W-1:0], cand_end[AB-1:0]};
        free_cnt_d = free_cnt_q + ONE_C;
        state_d    = S_RSV_CHK;
      end

      S_CRV_MOVE_RD: begin
        free_re = 1'b1;
        free_ra = free_cnt_q[IDX_W-1:0];
        state_d = S_CRV_MOVE_EV;
      end

      S_CRV_MOVE_EV: begin
        free_we = 1'b1;
        free_wd = free_rd;
        state_d = S_RSV_CHK;
      end

      S_CHK_RD: begin
        if (j_q < held_cnt_q) begin
          held_re = 1'b1;
          held_ra = j_q[IDX_W-1:0];
          state_d = S_CHK_EV;
        end else begin
          state_d = S_DONE;
        end
      end

      S_CHK_EV: begin
        if (!sp.base_lt_hi) begin
          state_d = S_DONE;
        end else if (sp.end_gt_lo) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          j_d     = j_nx;
          state_d = S_CHK_RD;
        end
      end

      S_DONE: begin
        if (!out_val_q || m_axis_tready_i) begin
          out_val_d  = 1'b1;
          out_data_d = OUT_W'({held_tot_q, free_tot_q, status_q, hit_q, addr_q});
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= rlba_pkg::KIND_CLEAR;
      avail_q    <= 1'b0;
      lg_q       <= '0;
      cand_q     <= '0;
      re_q       <= '0;
      right_q    <= '0;
      size_q     <= '0;
      rv_base_q  <= '0;
      rv_size_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      key_q      <= '0;
      cur_val_q  <= 1'b0;
      new_pend_q <= 1'b0;
      cur_base_q <= '0;
      cur_end_q  <= '0;
      addr_q     <= '0;
      hit_q      <= 1'b0;
      status_q   <= rlba_pkg::STAT_OK;
      free_tot_q <= '0;
      held_tot_q <= '0;
      free_cnt_q <= '0;
      held_cnt_q <= '0;
      kbase_q    <= '0;
      kend_q     <= '0;
      out_val_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      avail_q    <= avail_d;
      lg_q       <= lg_d;
      cand_q     <= cand_d;
      re_q       <= re_d;
      right_q    <= right_d;
      size_q     <= size_d;
      rv_base_q  <= rv_base_d;
      rv_size_q  <= rv_size_d;
      i_q        <= i_d;
      j_q        <= j_d;
      key_q      <= key_d;
      cur_val_q  <= cur_val_d;
      new_pend_q <= new_pend_d;
      cur_base_q <= cur_base_d;
      cur_end_q  <= cur_end_d;
      addr_q     <= addr_d;
      hit_q      <= hit_d;
      status_q   <= status_d;
      free_tot_q <= free_tot_d;
      held_tot_q <= held_tot_d;
      free_cnt_q <= free_cnt_d;
      held_cnt_q <= held_cnt_d;
      kbase_q    <= kbase_d;
      kend_q     <= kend_d;
      out_val_q  <= out_val_d;
      out_data_q <= out_data_d;
    end
  end

  `RLBA_ASSERT(a_free_cnt_bound, free_cnt_q <= SLOTS_C, "free count above table depth")
  `RLBA_ASSERT(a_held_cnt_bound, held_cnt_q <= SLOTS_C, "held count above table depth")
  `RLBA_ASSERT_NEXT(a_accept_starts, in_acc, state_q == S_DISPATCH, "transfer not dispatched")
  `RLBA_ASSERT_IMPL(a_hit_clean, out_val_q && out_data_q[AB], out_data_q[AB-1:0] == '0, "hit with address")

endmodule
`default_nettype wire

// ===== rtl/core/rlba_table.sv =====
`default_nettype none
module rlba_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 105
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/rlba_span_unit.sv =====
`default_nettype none
module rlba_span_unit (
  input  wire logic [rlba_pkg::DATA_W-1:0] ent_base_i,
  input  wire logic [rlba_pkg::DATA_W-1:0] ent_size_i,
  input  wire logic [rlba_pkg::DATA_W-1:0] win_lo_i,
  input  wire logic [rlba_pkg::DATA_W-1:0] win_hi_i,
  output rlba_pkg::span_t                  span_o
);

  logic [rlba_pkg::DATA_W-1:0] ent_end;

  assign ent_end = ent_base_i + ent_size_i;

  always_comb begin
    span_o.ent_end    = ent_end;
    span_o.base_le_lo = ent_base_i <= win_lo_i;
    span_o.base_lt_hi = ent_base_i < win_hi_i;
    span_o.end_gt_lo  = ent_end > win_lo_i;
    span_o.end_ge_hi  = ent_end >= win_hi_i;
  end

endmodule
`default_nettype wire
